@@ src/tmx_pkg.sv @@
`default_nettype none

package tmx_pkg;

    // tape and program depths are powers of two, so wrapping is a truncation
    localparam int TAPE_DEPTH = 65536;
    localparam int PROG_DEPTH = 4096;

    localparam int PTR_W  = $clog2(TAPE_DEPTH);
    localparam int STEP_W = PTR_W + 1;
    localparam int IDX_W  = 12;

    localparam logic [IDX_W-1:0]  PROG_MASK = IDX_W'(PROG_DEPTH - 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(TAPE_DEPTH - 1);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(TAPE_DEPTH);

    // opcodes
    localparam logic [3:0] OP_END    = 4'd0;
    localparam logic [3:0] OP_SET    = 4'd1;
    localparam logic [3:0] OP_ADD    = 4'd2;
    localparam logic [3:0] OP_JZ     = 4'd3;
    localparam logic [3:0] OP_JNZ    = 4'd4;
    localparam logic [3:0] OP_SCAN   = 4'd5;
    localparam logic [3:0] OP_MOVE   = 4'd6;
    localparam logic [3:0] OP_OUTPUT = 4'd7;
    localparam logic [3:0] OP_INPUT  = 4'd8;
    localparam logic [3:0] OP_EXITNZ = 4'd9;

    // halt codes
    localparam logic [2:0] HALT_RUN     = 3'd0;
    localparam logic [2:0] HALT_END     = 3'd1;
    localparam logic [2:0] HALT_EXIT    = 3'd2;
    localparam logic [2:0] HALT_EOF     = 3'd3;
    localparam logic [2:0] HALT_NO_ZERO = 3'd4;

    // end-of-input modes
    localparam logic [1:0] EOF_STORE_FF   = 2'd0;
    localparam logic [1:0] EOF_STORE_ZERO = 2'd1;
    localparam logic [1:0] EOF_KEEP       = 2'd2;
    localparam logic [1:0] EOF_HALT       = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]   instr_index;
        logic [3:0]         opcode;
        logic signed [15:0] pre_move;
        logic signed [15:0] argument;
        logic [7:0]         in_byte;
        logic               in_eof;
    } tmx_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] next_index;
        logic             out_valid;
        logic [7:0]       out_byte;
        logic [2:0]       halt_status;
    } tmx_out_t;

endpackage

`default_nettype wire

@@ src/tmx_in_if.sv @@
`default_nettype none

interface tmx_in_if import tmx_pkg::*; ();
    logic    valid;
    logic    ready;
    tmx_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/tmx_out_if.sv @@
`default_nettype none

interface tmx_out_if import tmx_pkg::*; ();
    logic     valid;
    logic     ready;
    tmx_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/tape_machine_execute_unit.sv @@
// channel   dir   payload                                           transfer when
// instr     in    instr_index opcode pre_move argument in_byte eof  valid && ready
// result    out   next_index out_valid out_byte halt_status         valid && ready
// cfg       in    cfg_wdata (eof_mode)                              cfg_we
//
// an item is accepted with a tape read, then executed and written back
// a scan adds a tape read per stride, at most TAPE_DEPTH strides
// after reset a clearing pass zeroes the tape, instr.ready low
// one result register; an item is accepted while a result waits, and a finished
// item holds in a pending register until the result register frees
`default_nettype none

module tape_machine_execute_unit import tmx_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmx_in_if.sink     instr,
    tmx_out_if.source  result,
    input  wire logic  cfg_we,
    input  wire logic [1:0] cfg_wdata
);

    // sequencer codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [PTR_W-1:0]  clr_reg, clr_next;
    logic [1:0]        eof_mode_reg;
    tmx_in_t           item_reg;
    tmx_out_t          pend_reg;
    tmx_out_t          res_reg;
    logic              res_full_reg;

    // tape memory, one write and one registered read per cycle
    logic [7:0]        tape [TAPE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [7:0]        wr_data;

    tmx_out_t          exec_res;
    tmx_out_t          load_val;
    logic              load_res;
    logic              exec_done;
    logic              out_free;
    logic [7:0]        cur_byte;

    assign cur_byte = rd_data_reg;
    assign out_free = !res_full_reg || result.ready;

    assign instr.ready    = (state_reg == S_IDLE);
    assign result.valid   = res_full_reg;
    assign result.payload = res_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        steps_next = steps_reg;
        clr_next   = clr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = '0;
        exec_done  = 1'b0;
        load_res   = 1'b0;

        exec_res.next_index  = IDX_W'(item_reg.instr_index + 12'd1) & PROG_MASK;
        exec_res.out_valid   = 1'b0;
        exec_res.out_byte    = '0;
        exec_res.halt_status = HALT_RUN;
        load_val             = exec_res;

        case (state_reg)
            S_CLEAR:
            begin
                // zero one cell a cycle
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == PTR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (instr.valid)
                begin
                    // pre-move wraps by truncation, tape read issued at new pointer
                    ptr_next   = ptr_reg + PTR_W'(instr.payload.pre_move);
                    steps_next = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                exec_done = 1'b1;
                case (item_reg.opcode)
                    OP_END:
                    begin
                        exec_res.halt_status = HALT_END;
                    end
                    OP_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_data = item_reg.argument[7:0];
                    end
                    OP_ADD:
                    begin
                        wr_en   = 1'b1;
                        wr_data = cur_byte + item_reg.argument[7:0];
                    end
                    OP_JZ, OP_JNZ:
                    begin
                        if ((cur_byte == 8'd0) == (item_reg.opcode == OP_JZ))
                        begin
                            exec_res.next_index =
                                IDX_W'(item_reg.argument + 16'sd1) & PROG_MASK;
                        end
                    end
                    OP_SCAN:
                    begin
                        if (cur_byte != 8'd0)
                        begin
                            if (steps_reg == STEP_MAX)
                            begin
                                exec_res.halt_status = HALT_NO_ZERO;
                            end
                            else
                            begin
                                // stride and read the next cell, stay here
                                exec_done  = 1'b0;
                                ptr_next   = ptr_reg + PTR_W'(item_reg.argument);
                                steps_next = steps_reg + 1'b1;
                            end
                        end
                    end
                    OP_MOVE:
                    begin
                        ptr_next = ptr_reg + PTR_W'(item_reg.argument);
                    end
                    OP_OUTPUT:
                    begin
                        exec_res.out_valid = 1'b1;
                        exec_res.out_byte  = cur_byte;
                    end
                    OP_INPUT:
                    begin
                        if (!item_reg.in_eof)
                        begin
                            wr_en   = 1'b1;
                            wr_data = item_reg.in_byte;
                        end
                        else
                        begin
                            case (eof_mode_reg)
                                EOF_STORE_FF:
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = 8'hFF;
                                end
                                EOF_STORE_ZERO:
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = 8'h00;
                                end
                                EOF_HALT:
                                begin
                                    exec_res.halt_status = HALT_EOF;
                                end
                                default:
                                begin
                                    // keep the cell
                                end
                            endcase
                        end
                    end
                    OP_EXITNZ:
                    begin
                        if (cur_byte != 8'd0)
                        begin
                            exec_res.halt_status = HALT_EXIT;
                        end
                    end
                    default:
                    begin
                        // unused opcodes only apply the pre-move
                    end
                endcase
                load_val = exec_res;
                if (exec_done)
                begin
                    if (out_free)
                    begin
                        load_res   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                load_val = pend_reg;
                if (out_free)
                begin
                    load_res   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ptr_reg      <= '0;
            steps_reg    <= '0;
            clr_reg      <= '0;
            eof_mode_reg <= EOF_KEEP;
            res_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            steps_reg <= steps_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                eof_mode_reg <= cfg_wdata;
            end
            if (load_res)
            begin
                res_full_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_full_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            item_reg <= instr.payload;
        end
        if (state_reg == S_EXEC)
        begin
            pend_reg <= exec_res;
        end
        if (load_res)
        begin
            res_reg <= load_val;
        end
    end

    // tape: reads always follow the next pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tape[wr_addr] <= wr_data;
        end
        rd_data_reg <= tape[ptr_next];
    end

endmodule

`default_nettype wire

@@ src/tmx_checker.sv @@
`default_nettype none

module tmx_checker import tmx_pkg::*; (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire tmx_out_t out_payload
);

    // one item at a time: no accept right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("stalled result changed");

endmodule

bind tape_machine_execute_unit tmx_checker u_tmx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (instr.valid),
    .in_ready    (instr.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);

`default_nettype wire
